@@ src/swdh_pkg.sv @@
`default_nettype none

package swdh_pkg;

    // Longest line sequence that one command may send.
    localparam int MAX_SEQ_BITS = 64;

    // Width of a data word on the wire, and of the bit counter.
    localparam int WORD_BITS = 32;
    localparam int COUNT_W   = 7;

    // Completion status codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FAULT   = 3'd1;
    localparam logic [2:0] ST_PARITY  = 3'd2;
    localparam logic [2:0] ST_UNKNOWN = 3'd3;
    localparam logic [2:0] ST_SEQ     = 3'd4;

    // Acknowledge codes as received, first bit in bit 0.
    localparam logic [2:0] ACK_OK    = 3'b001;
    localparam logic [2:0] ACK_WAIT  = 3'b010;
    localparam logic [2:0] ACK_FAULT = 3'b100;

    // Level the line keeps between commands.
    localparam logic [1:0] LINE_LOW  = 2'd0;
    localparam logic [1:0] LINE_HIGH = 2'd1;
    localparam logic [1:0] LINE_REL  = 2'd2;

    // One input beat: one SWCLK period.
    typedef struct packed {
        logic        cmd_valid;
        logic        op;
        logic [3:0]  request;
        logic [31:0] write_data;
        logic [63:0] seq_data;
        logic [6:0]  seq_length;
        logic        dio_in;
    } t_in_beat;

    // One result beat: what the wire and the status show in that period.
    typedef struct packed {
        logic        dio_out;
        logic        dio_drive;
        logic        busy_res;
        logic        done_res;
        logic [2:0]  status;
        logic [2:0]  raw_ack;
        logic [31:0] read_data;
    } t_out_beat;

    // A classified beat as it waits in the queue between front and back.
    typedef struct packed {
        logic               start_seq;
        logic               start_xfer;
        logic [3:0]         request;
        logic [31:0]        write_data;
        logic [63:0]        seq_data;
        logic [COUNT_W-1:0] seq_len;
        logic               dio;
    } t_item;

endpackage

`default_nettype wire

@@ src/swd_host_transfer_engine_core.sv @@
`default_nettype none

// Channel   Direction  Handshake                Payload
// -------   ---------  -----------------------  ----------------------------------
// in        input      i_in_valid / o_in_stall  i_in  : one SWCLK period, command
// out       output     o_out_valid / i_out_stall o_out : wire levels and status
//
// Every input beat yields exactly one output beat; one beat is taken every clock unless
// the queue is full. A result is offered once registered: the beat enters the queue at
// its accepting edge, and the protocol step registers the result from the queue head.
// Reset is synchronous on i_rst_n low and leaves the engine idle with the line driven low.
// A stall at the output holds the result; the two-entry queue then fills and stalls input.

module swd_host_transfer_engine_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire swdh_pkg::t_in_beat  i_in,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output swdh_pkg::t_out_beat      o_out
);
    import swdh_pkg::*;

    // Classified beats waiting for the protocol engine.
    logic  item_valid;
    t_item item;
    logic  pop;

    // The front decodes each beat into start-sequence or start-transfer and
    // saturates the sequence length, then holds it in a short queue.
    swdh_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in         (i_in),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_pop        (pop)
    );

    // The back runs the wire protocol one period per beat and registers
    // the result; it takes the next beat whenever its output register frees.
    swdh_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out        (o_out)
    );

endmodule

`default_nettype wire

@@ src/swdh_front.sv @@
`default_nettype none

module swdh_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire swdh_pkg::t_in_beat i_in,
    output logic                  o_item_valid,
    output swdh_pkg::t_item       o_item,
    input  wire logic             i_pop
);
    import swdh_pkg::*;

    t_item      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;
    logic       push;
    logic       pop;
    t_item      cls;

    // Decode the command and saturate the sequence length on the way in.
    always_comb begin
        cls.start_seq  = i_in.cmd_valid & i_in.op;
        cls.start_xfer = i_in.cmd_valid & ~i_in.op;
        cls.request    = i_in.request;
        cls.write_data = i_in.write_data;
        cls.seq_data   = i_in.seq_data;
        cls.seq_len    = (i_in.seq_length > COUNT_W'(MAX_SEQ_BITS)) ?
                         COUNT_W'(MAX_SEQ_BITS) : i_in.seq_length;
        cls.dio        = i_in.dio_in;
    end

    assign o_in_stall   = (r_count == 2'd2);
    assign push         = i_in_valid & ~o_in_stall;
    assign pop          = i_pop & (r_count != 2'd0);
    assign o_item_valid = (r_count != 2'd0);
    assign o_item       = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ push;
        n_rd_ptr = r_rd_ptr ^ pop;
        n_count  = r_count + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= cls;
        end
    end

endmodule

`default_nettype wire

@@ src/swdh_back.sv @@
`default_nettype none

module swdh_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_item_valid,
    input  wire swdh_pkg::t_item i_item,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output swdh_pkg::t_out_beat  o_out
);
    import swdh_pkg::*;

    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_SEQ       = 4'd1;
    localparam logic [3:0] PH_REQ       = 4'd2;
    localparam logic [3:0] PH_TRN_A     = 4'd3;
    localparam logic [3:0] PH_ACK       = 4'd4;
    localparam logic [3:0] PH_TRN_W     = 4'd5;
    localparam logic [3:0] PH_WDATA     = 4'd6;
    localparam logic [3:0] PH_RDATA     = 4'd7;
    localparam logic [3:0] PH_RPAR      = 4'd8;
    localparam logic [3:0] PH_TRN_R     = 4'd9;
    localparam logic [3:0] PH_LOW       = 4'd10;
    localparam logic [3:0] PH_TRN_WAIT  = 4'd11;
    localparam logic [3:0] PH_TRN_FAULT = 4'd12;

    logic [3:0]         r_phase;
    logic [COUNT_W-1:0] r_bit_count;
    logic [63:0]        r_shift;
    logic               r_parity;
    logic [3:0]         r_held;
    logic [2:0]         r_ack;
    logic [1:0]         r_line;
    logic               r_out_valid;
    t_out_beat          r_out;

    logic [3:0]         n_phase;
    logic [COUNT_W-1:0] n_bit_count;
    logic [63:0]        n_shift;
    logic               n_parity;
    logic [3:0]         n_held;
    logic [2:0]         n_ack;
    logic [1:0]         n_line;
    t_out_beat          n_out;

    logic               run;
    logic               is_read;
    logic               tx_bit;
    logic               load;

    // Request frame: start, APnDP, RnW, A2, A3, parity, stop, park.
    function automatic logic req_bit(input logic [3:0] req, input logic [2:0] k);
        logic b;
        unique case (k)
            3'd0:    b = 1'b1;
            3'd1:    b = req[0];
            3'd2:    b = req[1];
            3'd3:    b = req[2];
            3'd4:    b = req[3];
            3'd5:    b = ^req;
            3'd6:    b = 1'b0;
            default: b = 1'b1;
        endcase
        return b;
    endfunction

    assign load        = i_item_valid & (~r_out_valid | ~i_out_stall);
    assign o_pop       = load;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_phase     = (r_phase > PH_TRN_FAULT) ? PH_IDLE : r_phase;
        n_bit_count = r_bit_count;
        n_shift     = r_shift;
        n_parity    = r_parity;
        n_held      = r_held;
        n_ack       = r_ack;
        n_line      = r_line;
        n_out          = '0;
        n_out.busy_res = 1'b1;
        run    = 1'b1;
        tx_bit = 1'b0;

        if (n_phase == PH_IDLE) begin
            if (!i_item.start_seq && !i_item.start_xfer) begin
                n_out.dio_out   = (r_line == LINE_REL) ? 1'b0 : r_line[0];
                n_out.dio_drive = (r_line != LINE_REL);
                n_out.busy_res  = 1'b0;
                run = 1'b0;
            end else if (i_item.start_seq) begin
                n_shift     = i_item.seq_data;
                n_bit_count = i_item.seq_len;
                if (i_item.seq_len == '0) begin
                    // An empty sequence completes at once and leaves the line alone.
                    n_out.dio_out   = (r_line == LINE_REL) ? 1'b0 : r_line[0];
                    n_out.dio_drive = (r_line != LINE_REL);
                    n_out.done_res  = 1'b1;
                    n_out.status    = ST_SEQ;
                    run = 1'b0;
                end else begin
                    n_phase = PH_SEQ;
                end
            end else begin
                n_held      = i_item.request;
                n_shift     = {32'd0, i_item.write_data};
                n_bit_count = '0;
                n_parity    = 1'b0;
                n_ack       = 3'd0;
                n_phase     = PH_REQ;
            end
        end

        is_read = n_held[1];

        if (run) begin
            unique case (n_phase)
                PH_SEQ: begin
                    tx_bit          = n_shift[0];
                    n_out.dio_out   = tx_bit;
                    n_out.dio_drive = 1'b1;
                    n_shift         = n_shift >> 1;
                    n_bit_count     = n_bit_count - COUNT_W'(1);
                    if (n_bit_count == '0) begin
                        n_out.done_res = 1'b1;
                        n_out.status   = ST_SEQ;
                        n_line         = tx_bit ? LINE_HIGH : LINE_LOW;
                        n_phase        = PH_IDLE;
                    end
                end
                PH_REQ: begin
                    n_out.dio_out   = req_bit(n_held, n_bit_count[2:0]);
                    n_out.dio_drive = 1'b1;
                    n_bit_count     = n_bit_count + COUNT_W'(1);
                    if (n_bit_count >= COUNT_W'(8)) begin
                        n_bit_count = '0;
                        n_phase     = PH_TRN_A;
                    end
                end
                PH_TRN_A: begin
                    n_bit_count = '0;
                    n_ack       = 3'd0;
                    n_phase     = PH_ACK;
                end
                PH_ACK: begin
                    case (n_bit_count[1:0])
                        2'd0:    n_ack[0] = n_ack[0] | i_item.dio;
                        2'd1:    n_ack[1] = n_ack[1] | i_item.dio;
                        2'd2:    n_ack[2] = n_ack[2] | i_item.dio;
                        default: n_ack = n_ack;
                    endcase
                    n_bit_count = n_bit_count + COUNT_W'(1);
                    if (n_bit_count >= COUNT_W'(3)) begin
                        n_bit_count = '0;
                        n_parity    = 1'b0;
                        if (n_ack == ACK_OK) begin
                            if (is_read) begin
                                n_shift = '0;
                                n_phase = PH_RDATA;
                            end else begin
                                n_phase = PH_TRN_W;
                            end
                        end else if (n_ack == ACK_WAIT) begin
                            n_phase = PH_TRN_WAIT;
                        end else if (n_ack == ACK_FAULT) begin
                            n_phase = PH_TRN_FAULT;
                        end else begin
                            // Unrecognized ack: give up and leave the line to the target.
                            n_out.done_res = 1'b1;
                            n_out.status   = ST_UNKNOWN;
                            n_out.raw_ack  = n_ack;
                            n_line         = LINE_REL;
                            n_phase        = PH_IDLE;
                        end
                    end
                end
                PH_TRN_W: begin
                    n_bit_count = '0;
                    n_parity    = 1'b0;
                    n_phase     = PH_WDATA;
                end
                PH_WDATA: begin
                    if (n_bit_count < COUNT_W'(WORD_BITS)) begin
                        tx_bit   = n_shift[n_bit_count[4:0]];
                        n_parity = n_parity ^ tx_bit;
                    end else begin
                        tx_bit = n_parity;
                    end
                    n_out.dio_out   = tx_bit;
                    n_out.dio_drive = 1'b1;
                    n_bit_count     = n_bit_count + COUNT_W'(1);
                    if (n_bit_count > COUNT_W'(WORD_BITS)) begin
                        n_bit_count = '0;
                        n_parity    = 1'b0;
                        n_phase     = PH_LOW;
                    end
                end
                PH_RDATA: begin
                    n_shift[n_bit_count[4:0]] = n_shift[n_bit_count[4:0]] | i_item.dio;
                    n_parity    = n_parity ^ i_item.dio;
                    n_bit_count = n_bit_count + COUNT_W'(1);
                    if (n_bit_count >= COUNT_W'(WORD_BITS)) begin
                        n_bit_count = '0;
                        n_phase     = PH_RPAR;
                    end
                end
                PH_RPAR: begin
                    n_parity = n_parity ^ i_item.dio;
                    n_phase  = PH_TRN_R;
                end
                PH_TRN_R: begin
                    n_bit_count = '0;
                    n_phase     = PH_LOW;
                end
                PH_LOW: begin
                    n_out.dio_out   = 1'b0;
                    n_out.dio_drive = 1'b1;
                    n_bit_count     = n_bit_count + COUNT_W'(1);
                    if (n_bit_count >= COUNT_W'(2)) begin
                        n_out.done_res  = 1'b1;
                        n_out.status    = (is_read && n_parity) ? ST_PARITY : ST_OK;
                        n_out.raw_ack   = n_ack;
                        n_out.read_data = is_read ? n_shift[31:0] : 32'd0;
                        n_bit_count     = '0;
                        n_parity        = 1'b0;
                        n_line          = LINE_HIGH;
                        n_phase         = PH_IDLE;
                    end
                end
                PH_TRN_WAIT: begin
                    n_bit_count = '0;
                    n_phase     = PH_REQ;
                end
                PH_TRN_FAULT: begin
                    n_out.done_res = 1'b1;
                    n_out.status   = ST_FAULT;
                    n_out.raw_ack  = n_ack;
                    n_line         = LINE_HIGH;
                    n_phase        = PH_IDLE;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bit_count <= '0;
            r_parity    <= 1'b0;
            r_held      <= 4'd0;
            r_ack       <= 3'd0;
            r_line      <= LINE_LOW;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_phase     <= n_phase;
                r_bit_count <= n_bit_count;
                r_parity    <= n_parity;
                r_held      <= n_held;
                r_ack       <= n_ack;
                r_line      <= n_line;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_shift <= n_shift;
            r_out   <= n_out;
        end
    end

endmodule

`default_nettype wire

@@ src/swdh_checker.sv @@
`default_nettype none

module swdh_checker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                o_out_valid,
    input  wire logic                i_out_stall,
    input  wire swdh_pkg::t_out_beat o_out
);
    import swdh_pkg::*;

    // A stalled result beat stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // Completion is only reported in a busy period.
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.done_res |-> o_out.busy_res)
        else $error("done without busy");

    // Status and ack read as zero outside the completing period.
    a_quiet_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.done_res |-> o_out.status == ST_OK && o_out.raw_ack == 3'd0
            && o_out.read_data == 32'd0)
        else $error("status fields set outside completion");

    // A released line shows low.
    a_released_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.dio_drive |-> !o_out.dio_out)
        else $error("released line shows a high level");

    // Status never takes a code beyond sequence-sent.
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.status <= ST_SEQ)
        else $error("status code out of range");

endmodule

bind swd_host_transfer_engine_core swdh_checker u_swdh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

`default_nettype wire

@@ tb/swdh_tb_pkg.sv @@
`timescale 1ns / 100ps

// Command and request encodings that both the stimulus and the checker use.
package swdh_tb_pkg;

    localparam logic OP_XFER = 1'b0;
    localparam logic OP_SEQ  = 1'b1;

    // Position of RnW in the four request bits.
    localparam int REQ_RNW = 1;

endpackage

@@ tb/swdh_wire_checker.sv @@
`timescale 1ns / 100ps

module swdh_wire_checker (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_stall,
    input  wire swdh_pkg::t_in_beat  i_in,
    input  wire logic                i_out_valid,
    input  wire logic                i_out_stall,
    input  wire swdh_pkg::t_out_beat i_out,
    output int                       o_fail_count,
    output int                       o_pending,
    output int                       o_beats_checked
);
    import swdh_pkg::*;
    import swdh_tb_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SEQ, S_REQ, S_TRN_ACK, S_ACK, S_TRN_WR, S_WDATA,
        S_RDATA, S_RPAR, S_TRN_RD, S_LOW, S_TRN_WAIT, S_TRN_FAULT
    } t_wire_phase;

    // Shadow copy of the engine state.
    t_wire_phase eng_phase;
    logic [6:0]  bit_cnt;
    logic [63:0] shift_reg;
    logic        par_acc;
    logic [3:0]  req_hold;
    logic [2:0]  ack_got;
    logic [1:0]  line_state;

    t_out_beat expected_wire[$];
    int        fails   = 0;
    int        checked = 0;

    function automatic void reset_engine();
        eng_phase  = S_IDLE;
        bit_cnt    = '0;
        shift_reg  = '0;
        par_acc    = 1'b0;
        req_hold   = '0;
        ack_got    = '0;
        line_state = LINE_LOW;
    endfunction

    // Advances the shadow engine by one SWCLK period and returns what the wire
    // and the status should show in it.
    function automatic t_out_beat step_engine(t_in_beat b);
        t_out_beat  r;
        logic [7:0] frame;
        logic [6:0] len;
        logic       wire_bit;
        logic       is_read;
        r = '0;
        r.busy_res = 1'b1;
        if (eng_phase == S_IDLE) begin
            if (!b.cmd_valid) begin
                r.dio_out   = (line_state == LINE_HIGH);
                r.dio_drive = (line_state != LINE_REL);
                r.busy_res  = 1'b0;
                return r;
            end
            if (b.op == OP_SEQ) begin
                len = (b.seq_length > 7'(MAX_SEQ_BITS)) ? 7'(MAX_SEQ_BITS) : b.seq_length;
                shift_reg = b.seq_data;
                bit_cnt   = len;
                if (len == 7'd0) begin
                    r.dio_out   = (line_state == LINE_HIGH);
                    r.dio_drive = (line_state != LINE_REL);
                    r.done_res  = 1'b1;
                    r.status    = ST_SEQ;
                    return r;
                end
                eng_phase = S_SEQ;
            end else begin
                req_hold  = b.request;
                shift_reg = {32'h0, b.write_data};
                bit_cnt   = '0;
                par_acc   = 1'b0;
                ack_got   = '0;
                eng_phase = S_REQ;
            end
        end

        is_read = req_hold[REQ_RNW];
        // Start, four request bits, even parity, stop, park; bit 0 goes first.
        frame = {1'b1, 1'b0, ^req_hold, req_hold, 1'b1};

        case (eng_phase)
            S_SEQ: begin
                wire_bit    = shift_reg[0];
                r.dio_out   = wire_bit;
                r.dio_drive = 1'b1;
                shift_reg   = shift_reg >> 1;
                bit_cnt     = bit_cnt - 7'd1;
                if (bit_cnt == 7'd0) begin
                    r.done_res = 1'b1;
                    r.status   = ST_SEQ;
                    line_state = wire_bit ? LINE_HIGH : LINE_LOW;
                    eng_phase  = S_IDLE;
                end
            end
            S_REQ: begin
                r.dio_out   = frame[bit_cnt[2:0]];
                r.dio_drive = 1'b1;
                bit_cnt     = bit_cnt + 7'd1;
                if (bit_cnt >= 7'd8) begin
                    bit_cnt   = '0;
                    eng_phase = S_TRN_ACK;
                end
            end
            S_TRN_ACK: begin
                bit_cnt   = '0;
                ack_got   = '0;
                eng_phase = S_ACK;
            end
            S_ACK: begin
                ack_got[bit_cnt[1:0]] = ack_got[bit_cnt[1:0]] | b.dio_in;
                bit_cnt = bit_cnt + 7'd1;
                if (bit_cnt >= 7'd3) begin
                    bit_cnt = '0;
                    par_acc = 1'b0;
                    if (ack_got == ACK_OK) begin
                        if (is_read) begin
                            shift_reg = '0;
                            eng_phase = S_RDATA;
                        end else begin
                            eng_phase = S_TRN_WR;
                        end
                    end else if (ack_got == ACK_WAIT) begin
                        eng_phase = S_TRN_WAIT;
                    end else if (ack_got == ACK_FAULT) begin
                        eng_phase = S_TRN_FAULT;
                    end else begin
                        r.done_res = 1'b1;
                        r.status   = ST_UNKNOWN;
                        r.raw_ack  = ack_got;
                        line_state = LINE_REL;
                        eng_phase  = S_IDLE;
                    end
                end
            end
            S_TRN_WR: begin
                bit_cnt   = '0;
                par_acc   = 1'b0;
                eng_phase = S_WDATA;
            end
            S_WDATA: begin
                if (bit_cnt < 7'(WORD_BITS)) begin
                    wire_bit = shift_reg[bit_cnt[4:0]];
                    par_acc  = par_acc ^ wire_bit;
                end else begin
                    wire_bit = par_acc;
                end
                r.dio_out   = wire_bit;
                r.dio_drive = 1'b1;
                bit_cnt     = bit_cnt + 7'd1;
                if (bit_cnt > 7'(WORD_BITS)) begin
                    bit_cnt   = '0;
                    par_acc   = 1'b0;
                    eng_phase = S_LOW;
                end
            end
            S_RDATA: begin
                shift_reg[bit_cnt[4:0]] = shift_reg[bit_cnt[4:0]] | b.dio_in;
                par_acc = par_acc ^ b.dio_in;
                bit_cnt = bit_cnt + 7'd1;
                if (bit_cnt >= 7'(WORD_BITS)) begin
                    bit_cnt   = '0;
                    eng_phase = S_RPAR;
                end
            end
            S_RPAR: begin
                par_acc   = par_acc ^ b.dio_in;
                eng_phase = S_TRN_RD;
            end
            S_TRN_RD: begin
                bit_cnt   = '0;
                eng_phase = S_LOW;
            end
            S_LOW: begin
                r.dio_drive = 1'b1;
                bit_cnt     = bit_cnt + 7'd1;
                if (bit_cnt >= 7'd2) begin
                    r.done_res  = 1'b1;
                    r.status    = (is_read && par_acc) ? ST_PARITY : ST_OK;
                    r.raw_ack   = ack_got;
                    r.read_data = is_read ? shift_reg[31:0] : 32'h0;
                    bit_cnt     = '0;
                    par_acc     = 1'b0;
                    line_state  = LINE_HIGH;
                    eng_phase   = S_IDLE;
                end
            end
            S_TRN_WAIT: begin
                bit_cnt   = '0;
                eng_phase = S_REQ;
            end
            S_TRN_FAULT: begin
                r.done_res = 1'b1;
                r.status   = ST_FAULT;
                r.raw_ack  = ack_got;
                line_state = LINE_HIGH;
                eng_phase  = S_IDLE;
            end
            default: begin
                eng_phase = S_IDLE;
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            fails++;
            $error("%s mismatch in result beat %0d: expected 0x%0h, got 0x%0h",
                   name, checked, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            reset_engine();
            expected_wire.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                expected_wire.push_back(step_engine(i_in));
            end
            if (i_out_valid && !i_out_stall) begin
                checked++;
                if (expected_wire.size() == 0) begin
                    fails++;
                    $error("result beat %0d arrived with no expectation waiting", checked);
                end else begin
                    want = expected_wire.pop_front();
                    check_field("dio_out", 32'(want.dio_out), 32'(i_out.dio_out));
                    check_field("dio_drive", 32'(want.dio_drive), 32'(i_out.dio_drive));
                    check_field("busy_res", 32'(want.busy_res), 32'(i_out.busy_res));
                    check_field("done_res", 32'(want.done_res), 32'(i_out.done_res));
                    check_field("status", 32'(want.status), 32'(i_out.status));
                    check_field("raw_ack", 32'(want.raw_ack), 32'(i_out.raw_ack));
                    check_field("read_data", want.read_data, i_out.read_data);
                end
            end
        end
        o_fail_count    <= fails;
        o_pending       <= expected_wire.size();
        o_beats_checked <= checked;
    end

endmodule

@@ tb/tb_swd_host_transfer_engine_core.sv @@
`timescale 1ns / 100ps

module tb_swd_host_transfer_engine_core;
    import swdh_pkg::*;
    import swdh_tb_pkg::*;

    localparam int HALF_PERIOD  = 5;
    // Far more than a correct run needs, so only a hang ever reaches it.
    localparam int CYCLE_LIMIT  = 400_000;
    // Beats sent in the random part; the directed part adds about 590 more.
    localparam int RANDOM_BEATS = 460;
    // Clocks run after the final drain, leaving room for late result beats.
    localparam int TAIL_CYCLES  = 10;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_beat  in_beat   = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_beat out_beat;

    int   fail_count;
    int   pending;
    int   beats_checked;
    int   cycles     = 0;
    int   stall_left = 0;
    int   beats_sent = 0;
    int   xfers_sent = 0;
    int   seqs_sent  = 0;
    int   wait_xfers = 0;
    int   err_xfers  = 0;
    int   bad_reads  = 0;
    // When set, the sender puts beats back to back for a whole command.
    logic calm       = 1'b0;

    always #HALF_PERIOD clk = ~clk;

    swd_host_transfer_engine_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_beat)
    );

    swdh_wire_checker wire_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_in            (in_beat),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out           (out_beat),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_beats_checked (beats_checked)
    );

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver back-pressure. Each decision holds for a random stretch: mostly
    // short runs of either level, now and then a long stall, and now and then
    // a long quiet stretch in which results flow freely.
    always @(posedge clk) begin
        int roll;
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else begin
            roll = $urandom_range(99);
            if (roll < 55) begin
                out_stall  <= 1'b0;
                stall_left <= $urandom_range(1, 12);
            end else if (roll < 62) begin
                out_stall  <= 1'b0;
                stall_left <= $urandom_range(40, 200);
            end else if (roll < 94) begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(0, 3);
            end else begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(10, 40);
            end
        end
    end

    // Idle cycles before the next beat: mostly none or a few, rarely many.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (calm || roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // A beat with every field random. Inside a command the engine ignores
    // cmd_valid and the command fields, so this also serves as noise there.
    function automatic t_in_beat noise_beat();
        t_in_beat b;
        b.cmd_valid  = 1'($urandom_range(1));
        b.op         = 1'($urandom_range(1));
        b.request    = 4'($urandom_range(15));
        b.write_data = $urandom;
        b.seq_data   = {$urandom, $urandom};
        b.seq_length = 7'($urandom_range(127));
        b.dio_in     = 1'($urandom_range(1));
        return b;
    endfunction

    // Presents one beat after an optional gap and returns once it is taken.
    // Valid is lowered only in a step where it is not raised again, and the
    // payload holds still for as long as the engine stalls it.
    task automatic put_beat(input t_in_beat b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        beats_sent++;
    endtask

    task automatic pad_beats(input int count);
        for (int n = 0; n < count; n++) put_beat(noise_beat());
    endtask

    // One SWCLK period in which the target puts the given level on SWDIO.
    task automatic put_wire_bit(input logic level);
        t_in_beat b;
        b = noise_beat();
        b.dio_in = level;
        put_beat(b);
    endtask

    task automatic run_idle(input int count);
        t_in_beat b;
        for (int n = 0; n < count; n++) begin
            b = noise_beat();
            b.cmd_valid = 1'b0;
            put_beat(b);
        end
    endtask

    // A raw line sequence: the command beat sends the first bit, so a sequence
    // of n bits (n capped at the maximum) takes n beats, or one if n is zero.
    task automatic run_seq(input logic [63:0] bits, input logic [6:0] len);
        t_in_beat b;
        int span;
        b = noise_beat();
        b.cmd_valid  = 1'b1;
        b.op         = OP_SEQ;
        b.seq_data   = bits;
        b.seq_length = len;
        span = (int'(len) > MAX_SEQ_BITS) ? MAX_SEQ_BITS : int'(len);
        put_beat(b);
        seqs_sent++;
        pad_beats(span - 1);
    endtask

    // A read or write transfer in which the target answers WAIT a number of
    // times and then gives the final ack. The script follows the wire timing:
    // eight request periods (the command beat is the first), one turnaround,
    // three ack periods; WAIT adds a turnaround before the request repeats.
    // On OK a read takes 32 data bits, parity, a turnaround and two low
    // periods; a write takes a turnaround, 33 driven periods and two low ones.
    // FAULT takes one more turnaround; any other ack ends at its third bit.
    task automatic run_xfer(input logic [3:0] req, input logic [31:0] wdata,
                            input int waits, input logic [2:0] final_ack,
                            input logic [31:0] rdata, input logic bad_parity);
        t_in_beat   b;
        logic [2:0] ack;
        b = noise_beat();
        b.cmd_valid  = 1'b1;
        b.op         = OP_XFER;
        b.request    = req;
        b.write_data = wdata;
        put_beat(b);
        xfers_sent++;
        if (waits > 0) wait_xfers++;
        if (final_ack != ACK_OK) err_xfers++;
        for (int attempt = 0; attempt <= waits; attempt++) begin
            ack = (attempt < waits) ? ACK_WAIT : final_ack;
            pad_beats(attempt == 0 ? 8 : 9);
            for (int k = 0; k < 3; k++) put_wire_bit(ack[k]);
            if (ack == ACK_WAIT) pad_beats(1);
        end
        if (final_ack == ACK_OK && req[REQ_RNW]) begin
            if (bad_parity) bad_reads++;
            for (int k = 0; k < WORD_BITS; k++) put_wire_bit(rdata[k]);
            put_wire_bit(^rdata ^ bad_parity);
            pad_beats(3);
        end else if (final_ack == ACK_OK) begin
            pad_beats(WORD_BITS + 4);
        end else if (final_ack == ACK_FAULT) begin
            pad_beats(1);
        end
    endtask

    // Mostly OK acks so that data phases are well exercised; the rest split
    // between FAULT and the acks the protocol does not define.
    task automatic random_xfer();
        logic [2:0]  final_ack;
        logic [31:0] rdata;
        int          roll;
        int          waits;
        roll = $urandom_range(99);
        if (roll < 70) begin
            final_ack = ACK_OK;
        end else if (roll < 80) begin
            final_ack = ACK_FAULT;
        end else begin
            do begin
                final_ack = 3'($urandom_range(7));
            end while (final_ack == ACK_OK || final_ack == ACK_WAIT ||
                       final_ack == ACK_FAULT);
        end
        roll = $urandom_range(9);
        if (roll == 0) rdata = 32'h0;
        else if (roll == 1) rdata = 32'hFFFF_FFFF;
        else rdata = $urandom;
        waits = ($urandom_range(99) < 15) ? int'($urandom_range(1, 3)) : 0;
        run_xfer(4'($urandom_range(15)), $urandom, waits, final_ack, rdata,
                 $urandom_range(99) < 20);
    endtask

    // Short sequences dominate; zero, full and oversized lengths show up too.
    task automatic random_seq();
        logic [6:0] len;
        int         roll;
        roll = $urandom_range(99);
        if (roll < 70) len = 7'($urandom_range(1, 16));
        else if (roll < 85) len = 7'($urandom_range(17, 64));
        else if (roll < 92) len = 7'd0;
        else len = 7'($urandom_range(65, 127));
        run_seq({$urandom, $urandom}, len);
    endtask

    // Holds the sender off until every result beat has come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin
        int beats_target;
        int scenario;
        int roll;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. The line starts driven low: idle periods show it, and
        // a zero-length sequence must leave it as it is.
        run_idle(3);
        run_seq(64'h0, 7'd0);
        // A full-length sequence of ones leaves the line driven high.
        run_seq(64'hFFFF_FFFF_FFFF_FFFF, 7'd64);
        run_idle(2);
        run_seq(64'h0, 7'd0);
        // Lengths past the maximum saturate.
        run_seq(64'hAAAA_AAAA_AAAA_AAAA, 7'd127);
        run_seq(64'h5555_5555_5555_5555, 7'd65);
        run_seq(64'h0000_0000_0000_0001, 7'd1);
        // OK transfers at the extremes of request and data.
        run_xfer(4'b0000, 32'hFFFF_FFFF, 0, ACK_OK, 32'h0, 1'b0);
        run_xfer(4'b1111, 32'h0, 0, ACK_OK, 32'hFFFF_FFFF, 1'b0);
        run_xfer(4'b0010, 32'h0, 0, ACK_OK, 32'h0, 1'b0);
        // A read whose parity bit is wrong still returns the word.
        run_xfer(4'b0110, 32'h0, 0, ACK_OK, 32'h8000_0001, 1'b1);
        // WAIT repeats the whole request, for a read and for a write.
        run_xfer(4'b1010, 32'h0, 2, ACK_OK, 32'h1234_5678, 1'b0);
        run_xfer(4'b0001, 32'h8765_4321, 1, ACK_OK, 32'h0, 1'b0);
        run_xfer(4'b1000, 32'h0, 0, ACK_FAULT, 32'h0, 1'b0);
        // An undefined ack leaves the line released; idle periods and a
        // zero-length sequence show that, and a later sequence drives again.
        run_xfer(4'b0100, 32'h0, 0, 3'b000, 32'h0, 1'b0);
        run_idle(2);
        run_seq(64'h0, 7'd0);
        run_seq(64'h0000_0000_0000_000F, 7'd4);
        run_xfer(4'b1101, 32'h0, 0, 3'b111, 32'h0, 1'b0);
        run_seq(64'h0000_0000_0000_0002, 7'd2);
        run_xfer(4'b0011, 32'h0, 0, 3'b011, 32'h0, 1'b0);
        run_idle(1);
        drain();

        // Random part: mostly well-formed commands with random content, with noise beats
        // inside every transfer and every sequence longer than one bit, and bare idle periods between.
        beats_target = beats_sent + RANDOM_BEATS;
        scenario     = 0;
        while (beats_sent < beats_target) begin
            calm = ($urandom_range(9) == 0);
            roll = $urandom_range(99);
            if (roll < 65) random_xfer();
            else if (roll < 90) random_seq();
            else run_idle($urandom_range(1, 4));
            scenario++;
            if (scenario % 8 == 0) drain();
        end
        calm = 1'b0;

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d input beats and %0d checked result beats: %0d transfers, %0d sequences.",
                 beats_sent, beats_checked, xfers_sent, seqs_sent);
        $display("Transfers with WAIT retries: %0d, ending on FAULT or undefined ack: %0d, bad read parity: %0d.",
                 wait_xfers, err_xfers, bad_reads);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
